/* hw/rtl/ipsmc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ipsmc_pkg
// shared types, constants and saturating helpers for the balance controller
// ----------------------------------------------------------------------------
package ipsmc_pkg;

  localparam int FracBits     = 16;
  localparam int QueueDepth   = 2;
  localparam int MulW         = 34;
  localparam int ProdW        = 2 * MulW;
  localparam int DvdW         = 32 + FracBits;
  localparam int SinShift     = 60 - FracBits;

  localparam logic signed [31:0] One        = 32'sd1 <<< FracBits;
  localparam logic signed [31:0] Half       = 32'sd1 <<< (FracBits - 1);
  localparam logic signed [31:0] PhiMin     = 32'(((1 << FracBits) + 9999) / 10000);
  localparam logic signed [31:0] AccelLimit = 32'sd327680;
  localparam logic signed [MulW-1:0] DampingCoeff = 34'sd6554;
  localparam logic signed [MulW-1:0] TurnPerRad   = 34'sd683565276;
  localparam logic [31:0] QuarterTurn = 32'h4000_0000;
  localparam logic [31:0] HalfTurn    = 32'h8000_0000;
  localparam logic [31:0] ThreeQuarterTurn = 32'hC000_0000;

  localparam logic signed [31:0] SinCoef [5] = '{
    32'sd172272, -32'sd5026995, 32'sd85569306, -32'sd693598669, 32'sd1686629713
  };

  typedef enum logic [7:0] {
    REG_TILT_GAIN  = 8'd0,
    REG_VEL_GAIN   = 8'd1,
    REG_POS_GAIN   = 8'd2,
    REG_REACH_GAIN = 8'd3,
    REG_SW_GAIN    = 8'd4,
    REG_BOUNDARY   = 8'd5,
    REG_GRAVITY    = 8'd6,
    REG_COUPLING   = 8'd7
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_SW,
    ST_SWWAIT,
    ST_UDIV,
    ST_UWAIT,
    ST_DONE
  } state_t;

  typedef enum logic [4:0] {
    OP_PHASE,
    OP_SIN_Z2,
    OP_SIN_P1,
    OP_SIN_P2,
    OP_SIN_P3,
    OP_SIN_P4,
    OP_SIN_Z,
    OP_COS_Z2,
    OP_COS_P1,
    OP_COS_P2,
    OP_COS_P3,
    OP_COS_P4,
    OP_COS_Z,
    OP_S_TILT,
    OP_S_VEL,
    OP_S_POS,
    OP_F_RATE,
    OP_F_VEL,
    OP_F_GRAV,
    OP_F_DAMP,
    OP_GAIN,
    OP_REACH_P,
    OP_REACH_K
  } op_t;

  typedef struct packed {
    logic signed [31:0] tilt_angle;
    logic signed [31:0] tilt_rate;
    logic signed [31:0] wheel_position;
    logic signed [31:0] wheel_velocity;
    logic signed [31:0] position_target;
    logic signed [31:0] velocity_target;
  } in_t;

  typedef struct packed {
    logic signed [31:0] accel_command;
    logic signed [31:0] surface_value;
    logic               gains_valid;
  } out_t;

  typedef struct packed {
    logic signed [31:0] tilt;
    logic signed [31:0] rate;
    logic signed [31:0] pos_err;
    logic signed [31:0] vel_err;
  } work_t;

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] t;
    t = {a[31], a} + {b[31], b};
    if (t[32] != t[31]) return t[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    return t[31:0];
  endfunction

  function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] t;
    t = {a[31], a} - {b[31], b};
    if (t[32] != t[31]) return t[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    return t[31:0];
  endfunction

  function automatic logic signed [31:0] sat_wide(input logic signed [ProdW-1:0] v);
    if (v > 68'sd2147483647) return 32'sh7fff_ffff;
    if (v < -68'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/ipsmc_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ipsmc_front
// accepts input transactions and forms the tracking errors for the queue
// ----------------------------------------------------------------------------
module ipsmc_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire ipsmc_pkg::in_t   in_data,
  output logic                  q_valid,
  input  wire logic             q_ready,
  output ipsmc_pkg::work_t      q_data
);

  logic             vld;
  ipsmc_pkg::work_t work;

  assign in_ready = !vld || q_ready;
  assign q_valid  = vld;
  assign q_data   = work;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_valid && in_ready) begin
      vld <= 1'b1;
    end else if (q_ready) begin
      vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      work.tilt    <= in_data.tilt_angle;
      work.rate    <= in_data.tilt_rate;
      work.pos_err <= ipsmc_pkg::sat_sub(in_data.wheel_position, in_data.position_target);
      work.vel_err <= ipsmc_pkg::sat_sub(in_data.wheel_velocity, in_data.velocity_target);
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/ipsmc_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ipsmc_fifo
// short queue between the front and the back end
// ----------------------------------------------------------------------------
module ipsmc_fifo (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push_valid,
  output logic                   push_ready,
  input  wire ipsmc_pkg::work_t  push_data,
  output logic                   pop_valid,
  input  wire logic              pop_ready,
  output ipsmc_pkg::work_t       pop_data
);

  localparam int PtrW = $clog2(ipsmc_pkg::QueueDepth);
  localparam int CntW = $clog2(ipsmc_pkg::QueueDepth + 1);

  ipsmc_pkg::work_t mem [ipsmc_pkg::QueueDepth];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = count != CntW'(ipsmc_pkg::QueueDepth);
  assign pop_valid  = count != '0;
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(ipsmc_pkg::QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(ipsmc_pkg::QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/ipsmc_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ipsmc_div
// restoring divider, one quotient bit per cycle, signed result
// ----------------------------------------------------------------------------
module ipsmc_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [ipsmc_pkg::DvdW-1:0]    dvd_mag,
  input  wire logic [31:0]                   dsr_mag,
  input  wire logic                          neg,
  output logic                               done,
  output logic signed [ipsmc_pkg::DvdW:0]    quo
);

  localparam int DvdW = ipsmc_pkg::DvdW;
  localparam int CntW = $clog2(DvdW + 1);

  logic [CntW-1:0] cnt;
  logic [31:0]     rem;
  logic [DvdW-1:0] dvd;
  logic [31:0]     dsr;
  logic            neg_r;
  logic [32:0]     rs;
  logic [32:0]     diff;
  logic            ge;

  assign rs   = {rem, dvd[DvdW-1]};
  assign diff = rs - {1'b0, dsr};
  assign ge   = rs >= {1'b0, dsr};
  assign quo  = neg_r ? -$signed({1'b0, dvd}) : $signed({1'b0, dvd});

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CntW'(DvdW);
      end else if (cnt != '0) begin
        cnt  <= cnt - 1'b1;
        done <= cnt == CntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      dvd   <= dvd_mag;
      dsr   <= dsr_mag;
      neg_r <= neg;
    end else if (cnt != '0) begin
      rem <= ge ? diff[31:0] : rs[31:0];
      dvd <= {dvd[DvdW-2:0], ge};
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/ipsmc_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ipsmc_back
// sequences phase, sine, cosine, surface, drift, gain and drive through one multiplier and divider
// ----------------------------------------------------------------------------
module ipsmc_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_valid,
  input  wire logic [7:0]        cfg_index,
  input  wire logic [31:0]       cfg_data,
  input  wire logic              q_valid,
  output logic                   q_ready,
  input  wire ipsmc_pkg::work_t  q_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output ipsmc_pkg::out_t        out_data
);

  localparam int MulW  = ipsmc_pkg::MulW;
  localparam int ProdW = ipsmc_pkg::ProdW;
  localparam int DvdW  = ipsmc_pkg::DvdW;

  // configuration
  logic [30:0]        ct;
  logic signed [31:0] cv;
  logic [30:0]        cx;
  logic [30:0]        eta;
  logic [30:0]        kk;
  logic [30:0]        phi;
  logic [30:0]        gc;
  logic [30:0]        cc;

  always_ff @(posedge clk) begin
    if (rst) begin
      ct  <= '0;
      cv  <= '0;
      cx  <= '0;
      eta <= '0;
      kk  <= '0;
      phi <= ipsmc_pkg::One[30:0];
      gc  <= '0;
      cc  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ipsmc_pkg::REG_TILT_GAIN:  ct  <= cfg_data[30:0];
        ipsmc_pkg::REG_VEL_GAIN:   cv  <= cfg_data;
        ipsmc_pkg::REG_POS_GAIN:   cx  <= cfg_data[30:0];
        ipsmc_pkg::REG_REACH_GAIN: eta <= cfg_data[30:0];
        ipsmc_pkg::REG_SW_GAIN:    kk  <= cfg_data[30:0];
        ipsmc_pkg::REG_BOUNDARY:   phi <= cfg_data[30:0];
        ipsmc_pkg::REG_GRAVITY:    gc  <= cfg_data[30:0];
        ipsmc_pkg::REG_COUPLING:   cc  <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  ipsmc_pkg::state_t state;
  ipsmc_pkg::state_t state_next;
  ipsmc_pkg::op_t    op;

  ipsmc_pkg::work_t   item;
  logic [31:0]        ph;
  logic signed [31:0] z2;
  logic signed [MulW-1:0] r;
  logic signed [31:0] sn;
  logic signed [31:0] cs;
  logic signed [31:0] s;
  logic signed [31:0] f;
  logic signed [31:0] gs;
  logic signed [31:0] num;
  logic signed [31:0] rch;
  logic signed [31:0] sw;
  logic signed [ProdW-1:0] prod;

  // operand selection
  logic               is_cos;
  logic [31:0]        ph_sel;
  logic [31:0]        ph_fold;
  logic signed [31:0] z;
  logic signed [MulW-1:0] mul_a;
  logic signed [MulW-1:0] mul_b;

  assign is_cos  = op >= ipsmc_pkg::OP_COS_Z2;
  assign ph_sel  = is_cos ? ph + ipsmc_pkg::QuarterTurn : ph;
  assign ph_fold = (ph_sel >= ipsmc_pkg::QuarterTurn && ph_sel < ipsmc_pkg::ThreeQuarterTurn)
                   ? ipsmc_pkg::HalfTurn - ph_sel : ph_sel;
  assign z       = $signed(ph_fold);

  function automatic logic signed [MulW-1:0] ext_u(input logic [30:0] v);
    return {3'b000, v};
  endfunction

  function automatic logic signed [MulW-1:0] ext_s(input logic signed [31:0] v);
    return {{2{v[31]}}, v};
  endfunction

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (op) inside
      ipsmc_pkg::OP_PHASE: begin
        mul_a = ext_s(item.tilt);
        mul_b = ipsmc_pkg::TurnPerRad;
      end
      ipsmc_pkg::OP_SIN_Z2, ipsmc_pkg::OP_COS_Z2: begin
        mul_a = ext_s(z);
        mul_b = ext_s(z);
      end
      [ipsmc_pkg::OP_SIN_P1:ipsmc_pkg::OP_SIN_P4],
      [ipsmc_pkg::OP_COS_P1:ipsmc_pkg::OP_COS_P4]: begin
        mul_a = r;
        mul_b = ext_s(z2);
      end
      ipsmc_pkg::OP_SIN_Z, ipsmc_pkg::OP_COS_Z: begin
        mul_a = ext_s(z);
        mul_b = r;
      end
      ipsmc_pkg::OP_S_TILT: begin
        mul_a = ext_u(ct);
        mul_b = ext_s(item.tilt);
      end
      ipsmc_pkg::OP_S_VEL: begin
        mul_a = ext_s(cv);
        mul_b = ext_s(item.vel_err);
      end
      ipsmc_pkg::OP_S_POS: begin
        mul_a = ext_u(cx);
        mul_b = ext_s(item.pos_err);
      end
      ipsmc_pkg::OP_F_RATE: begin
        mul_a = ext_u(ct);
        mul_b = ext_s(item.rate);
      end
      ipsmc_pkg::OP_F_VEL: begin
        mul_a = ext_u(cx);
        mul_b = ext_s(item.vel_err);
      end
      ipsmc_pkg::OP_F_GRAV: begin
        mul_a = ext_u(gc);
        mul_b = ext_s(sn);
      end
      ipsmc_pkg::OP_F_DAMP: begin
        mul_a = ipsmc_pkg::DampingCoeff;
        mul_b = ext_s(item.rate);
      end
      ipsmc_pkg::OP_GAIN: begin
        mul_a = ext_u(cc);
        mul_b = ext_s(cs);
      end
      ipsmc_pkg::OP_REACH_P: begin
        mul_a = ext_u(eta);
        mul_b = ext_s(s);
      end
      ipsmc_pkg::OP_REACH_K: begin
        mul_a = ext_u(kk);
        mul_b = ext_s(sw);
      end
      default: ;
    endcase
  end

  // product post-processing
  logic signed [ProdW-1:0] pq;
  logic signed [ProdW-1:0] p30;
  logic signed [ProdW-1:0] psin;
  logic signed [31:0]      mq;
  logic [2:0]              cidx;
  logic signed [MulW-1:0]  r_upd;
  logic signed [31:0]      gs_raw;
  logic signed [31:0]      reach_sum;

  assign pq   = prod >>> ipsmc_pkg::FracBits;
  assign p30  = prod >>> 30;
  assign psin = prod >>> ipsmc_pkg::SinShift;
  assign mq   = ipsmc_pkg::sat_wide(pq);
  assign cidx = is_cos ? 3'(op - ipsmc_pkg::OP_COS_Z2) : 3'(op - ipsmc_pkg::OP_SIN_Z2);
  assign r_upd = p30[MulW-1:0] + ext_s(ipsmc_pkg::SinCoef[cidx]);
  assign gs_raw = ipsmc_pkg::sat_sub(cv, mq);
  assign reach_sum = ipsmc_pkg::sat_add(rch, mq);

  // boundary layer and divider operands
  logic signed [32:0] phi_eff;
  logic signed [32:0] s_ext;
  logic [31:0]        s_mag;
  logic [31:0]        num_mag;
  logic [31:0]        gs_mag;
  logic               sw_inside;
  logic               div_start;
  logic [DvdW-1:0]    div_dvd;
  logic [31:0]        div_dsr;
  logic               div_neg;
  logic               div_done;
  logic signed [DvdW:0] div_quo;

  assign phi_eff   = ($signed({1'b0, phi}) < ipsmc_pkg::PhiMin) ?
                     {ipsmc_pkg::PhiMin[31], ipsmc_pkg::PhiMin} : {2'b00, phi};
  assign s_ext     = {s[31], s};
  assign s_mag     = s[31] ? 32'(-s) : 32'(s);
  assign num_mag   = num[31] ? 32'(-num) : 32'(num);
  assign gs_mag    = gs[31] ? 32'(-gs) : 32'(gs);
  assign sw_inside = (s_ext < phi_eff) && (s_ext > -phi_eff);

  always_comb begin
    if (state == ipsmc_pkg::ST_SW) begin
      div_dvd = {s_mag, {ipsmc_pkg::FracBits{1'b0}}};
      div_dsr = phi_eff[31:0];
      div_neg = s[31];
    end else begin
      div_dvd = {num_mag, {ipsmc_pkg::FracBits{1'b0}}};
      div_dsr = gs_mag;
      div_neg = num[31] ^ gs[31];
    end
  end

  ipsmc_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dvd_mag (div_dvd),
    .dsr_mag (div_dsr),
    .neg     (div_neg),
    .done    (div_done),
    .quo     (div_quo)
  );

  // drive clamp and gain check
  logic signed [31:0] u_clamp;
  logic signed [32:0] gain_diff;
  logic [32:0]        gain_mag;
  logic               out_load;

  always_comb begin
    if (div_quo > (DvdW+1)'(ipsmc_pkg::AccelLimit)) begin
      u_clamp = ipsmc_pkg::AccelLimit;
    end else if (div_quo < -(DvdW+1)'(ipsmc_pkg::AccelLimit)) begin
      u_clamp = -ipsmc_pkg::AccelLimit;
    end else begin
      u_clamp = div_quo[31:0];
    end
  end

  assign gain_diff = {cv[31], cv} - {2'b00, cc};
  assign gain_mag  = gain_diff[32] ? 33'(-gain_diff) : 33'(gain_diff);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ipsmc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_ready    = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ipsmc_pkg::ST_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          state_next = ipsmc_pkg::ST_MUL;
        end
      end
      ipsmc_pkg::ST_MUL: begin
        state_next = ipsmc_pkg::ST_ACC;
      end
      ipsmc_pkg::ST_ACC: begin
        if (op == ipsmc_pkg::OP_REACH_P) begin
          state_next = ipsmc_pkg::ST_SW;
        end else if (op == ipsmc_pkg::OP_REACH_K) begin
          state_next = ipsmc_pkg::ST_UDIV;
        end else begin
          state_next = ipsmc_pkg::ST_MUL;
        end
      end
      ipsmc_pkg::ST_SW: begin
        if (sw_inside) begin
          div_start  = 1'b1;
          state_next = ipsmc_pkg::ST_SWWAIT;
        end else begin
          state_next = ipsmc_pkg::ST_MUL;
        end
      end
      ipsmc_pkg::ST_SWWAIT: begin
        if (div_done) begin
          state_next = ipsmc_pkg::ST_MUL;
        end
      end
      ipsmc_pkg::ST_UDIV: begin
        div_start  = 1'b1;
        state_next = ipsmc_pkg::ST_UWAIT;
      end
      ipsmc_pkg::ST_UWAIT: begin
        if (div_done) begin
          state_next = ipsmc_pkg::ST_DONE;
        end
      end
      ipsmc_pkg::ST_DONE: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = ipsmc_pkg::ST_IDLE;
        end
      end
      default: state_next = ipsmc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op <= ipsmc_pkg::OP_PHASE;
    end else if (state == ipsmc_pkg::ST_IDLE) begin
      op <= ipsmc_pkg::OP_PHASE;
    end else if (state == ipsmc_pkg::ST_ACC && op != ipsmc_pkg::OP_REACH_K) begin
      op <= ipsmc_pkg::op_t'(op + 5'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ipsmc_pkg::ST_IDLE && q_valid) begin
      item <= q_data;
    end
    if (state == ipsmc_pkg::ST_MUL) begin
      prod <= mul_a * mul_b;
    end
    if (state == ipsmc_pkg::ST_ACC) begin
      unique case (op) inside
        ipsmc_pkg::OP_PHASE: ph <= pq[31:0];
        ipsmc_pkg::OP_SIN_Z2, ipsmc_pkg::OP_COS_Z2: begin
          z2 <= p30[31:0];
          r  <= ext_s(ipsmc_pkg::SinCoef[0]);
        end
        [ipsmc_pkg::OP_SIN_P1:ipsmc_pkg::OP_SIN_P4],
        [ipsmc_pkg::OP_COS_P1:ipsmc_pkg::OP_COS_P4]: r <= r_upd;
        ipsmc_pkg::OP_SIN_Z:   sn  <= psin[31:0];
        ipsmc_pkg::OP_COS_Z:   cs  <= psin[31:0];
        ipsmc_pkg::OP_S_TILT:  s   <= ipsmc_pkg::sat_add(item.rate, mq);
        ipsmc_pkg::OP_S_VEL, ipsmc_pkg::OP_S_POS: s <= ipsmc_pkg::sat_add(s, mq);
        ipsmc_pkg::OP_F_RATE:  f   <= mq;
        ipsmc_pkg::OP_F_VEL, ipsmc_pkg::OP_F_GRAV: f <= ipsmc_pkg::sat_add(f, mq);
        ipsmc_pkg::OP_F_DAMP:  f   <= ipsmc_pkg::sat_sub(f, mq);
        ipsmc_pkg::OP_GAIN: begin
          num <= ipsmc_pkg::sat_sub(32'sd0, f);
          if (gs_raw > -ipsmc_pkg::Half && gs_raw < ipsmc_pkg::Half) begin
            gs <= gs_raw[31] ? -ipsmc_pkg::Half : ipsmc_pkg::Half;
          end else begin
            gs <= gs_raw;
          end
        end
        ipsmc_pkg::OP_REACH_P: rch <= mq;
        ipsmc_pkg::OP_REACH_K: num <= ipsmc_pkg::sat_sub(num, reach_sum);
        default: ;
      endcase
    end
    if (state == ipsmc_pkg::ST_SW && !sw_inside) begin
      sw <= s[31] ? -ipsmc_pkg::One : ipsmc_pkg::One;
    end
    if (state == ipsmc_pkg::ST_SWWAIT && div_done) begin
      sw <= div_quo[31:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.accel_command <= u_clamp;
      out_data.surface_value <= s;
      out_data.gains_valid   <= gain_mag > 33'(ipsmc_pkg::Half);
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/inverted_pendulum_sliding_mode_control_top.sv */
`default_nettype none
// the back end takes one item at a time; each result waits on 23 products through one
//   shared multiplier and up to two divisions, and the switching division is skipped when
//   the surface lies outside the boundary layer
// the front end and queue keep taking items while the back end works, until the queue fills
// reset: synchronous; gains clear, boundary width returns to 1.0, queue empties
// ----------------------------------------------------------------------------
// inverted_pendulum_sliding_mode_control_top
// sliding mode balance controller with boundary layer
// ----------------------------------------------------------------------------
module inverted_pendulum_sliding_mode_control_top (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire ipsmc_pkg::in_t   in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output ipsmc_pkg::out_t       out_data,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [7:0]       cfg_index,
  input  wire logic [31:0]      cfg_data
);

  logic             f_valid;
  logic             f_ready;
  ipsmc_pkg::work_t f_data;
  logic             b_valid;
  logic             b_ready;
  ipsmc_pkg::work_t b_data;

  assign cfg_ready = 1'b1;

  ipsmc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (f_valid),
    .q_ready  (f_ready),
    .q_data   (f_data)
  );

  ipsmc_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_data),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (b_data)
  );

  ipsmc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (b_valid),
    .q_ready   (b_ready),
    .q_data    (b_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
